FILE: hdl/sha256_pkg.sv
// sha256_pkg: shared types, constants and round functions of the sha-256 hasher
// holds the round constant table, initial hash values and sigma/choice/majority logic
// no dependencies
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned WORD_BITS = 32;

  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;
  localparam logic [2:0] LEN_LANE_LAST = 3'd7;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WORD_BITS - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    unique case (r)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

FILE: hdl/sha256_stream_hasher.sv
// sha256_stream_hasher: byte-stream sha-256 with one round unit shared over 64 rounds
// a request with a byte is taken while idle; a full 64-byte block then stalls input
// (64 rounds plus chaining add), so no bytes are taken while a block is compressed
// end of message: 9 to 72 padding bytes, each padded block compressed, then 8 digest words
// synchronous active-low reset loads the initial hash values and empties the block
// depends on sha256_pkg
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [2:0] {ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_OUT} state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] count_r, count_nxt;
  logic        pad_act_r, pad_act_nxt;
  logic        mark_done_r, mark_done_nxt;
  logic        final_blk_r, final_blk_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  word_t       chain_r [8];
  word_t       chain_nxt [8];
  word_t       work_r [8];
  word_t       sched_r [16];

  logic        shift_en;
  logic [7:0]  shift_byte;
  logic [7:0]  pad_byte;
  logic        load_work;
  logic [63:0] len_bits;
  logic [2:0]  len_lane;
  word_t       w_new;
  word_t       t1;
  word_t       t2;

  // padding byte: marker, zeros, then big-endian bit length in the final block
  assign len_bits = {count_r, 3'b000};
  assign len_lane = LEN_LANE_LAST - fill_r[2:0];

  always_comb begin
    if (!mark_done_r) begin
      pad_byte = PAD_MARK;
    end else if (final_blk_r && (fill_r >= LEN_START)) begin
      pad_byte = len_bits[{len_lane, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    shift_en   = 1'b0;
    shift_byte = in_data_byte;
    if (state_r == ST_IDLE) begin
      shift_en = in_valid && in_has_byte;
    end else if (state_r == ST_PAD) begin
      shift_en   = 1'b1;
      shift_byte = pad_byte;
    end
  end

  assign load_work = shift_en && (fill_r == FILL_LAST);

  // shared round unit
  assign w_new = small_sig1(sched_r[14]) + sched_r[9] + small_sig0(sched_r[1]) + sched_r[0];
  assign t1 = work_r[7] + big_sig1(work_r[4]) + choose(work_r[4], work_r[5], work_r[6])
              + round_k(rnd_r) + sched_r[0];
  assign t2 = big_sig0(work_r[0]) + majority(work_r[0], work_r[1], work_r[2]);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    pad_act_nxt   = pad_act_r;
    mark_done_nxt = mark_done_r;
    final_blk_nxt = final_blk_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    chain_nxt     = chain_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_has_byte) begin
            fill_nxt  = fill_r + 6'd1;
            count_nxt = count_r + 61'd1;
          end
          if (in_end_of_message) begin
            pad_act_nxt   = 1'b1;
            mark_done_nxt = 1'b0;
            final_blk_nxt = 1'b0;
          end
          if (in_has_byte && (fill_r == FILL_LAST)) begin
            state_nxt = ST_ROUND;
            rnd_nxt   = '0;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        fill_nxt = fill_r + 6'd1;
        if (!mark_done_r) begin
          mark_done_nxt = 1'b1;
          if (fill_r < LEN_START) begin
            final_blk_nxt = 1'b1;
          end
        end
        if (fill_r == FILL_LAST) begin
          state_nxt = ST_ROUND;
          rnd_nxt   = '0;
        end
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == ROUND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int j = 0; j < 8; j++) begin
          chain_nxt[j] = chain_r[j] + work_r[j];
        end
        priority if (pad_act_r && final_blk_r) begin
          state_nxt = ST_OUT;
          idx_nxt   = '0;
        end else if (pad_act_r) begin
          state_nxt     = ST_PAD;
          final_blk_nxt = mark_done_r;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == WORD_LAST) begin
            state_nxt     = ST_IDLE;
            chain_nxt     = INIT_HASH;
            count_nxt     = '0;
            fill_nxt      = '0;
            pad_act_nxt   = 1'b0;
            mark_done_nxt = 1'b0;
            final_blk_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      count_r     <= '0;
      pad_act_r   <= 1'b0;
      mark_done_r <= 1'b0;
      final_blk_r <= 1'b0;
      rnd_r       <= '0;
      idx_r       <= '0;
      chain_r     <= INIT_HASH;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      pad_act_r   <= pad_act_nxt;
      mark_done_r <= mark_done_nxt;
      final_blk_r <= final_blk_nxt;
      rnd_r       <= rnd_nxt;
      idx_r       <= idx_nxt;
      chain_r     <= chain_nxt;
    end
  end

  // block bytes shift in big-endian, then the same line serves as the schedule window
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= {sched_r[i][23:0], sched_r[i+1][31:24]};
      end
      sched_r[15] <= {sched_r[15][23:0], shift_byte};
    end else if (state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (load_work) begin
      work_r <= chain_r;
    end else if (state_r == ST_ROUND) begin
      work_r[0] <= t1 + t2;
      work_r[1] <= work_r[0];
      work_r[2] <= work_r[1];
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3] + t1;
      work_r[5] <= work_r[4];
      work_r[6] <= work_r[5];
      work_r[7] <= work_r[6];
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = chain_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == WORD_LAST);

  // digest words only appear once the last block has been absorbed
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (fill_r == '0) && pad_act_r && final_blk_r && mark_done_r)
    else $error("digest shown before padding finished");

  // every compression starts at round zero
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_ROUND) |-> (rnd_r == '0))
    else $error("compression entered mid-round");

  // last digest word returns to idle with fresh chaining words
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=>
      (!out_valid && !in_stall && (chain_r[0] == INIT_HASH[0]) && (count_r == '0)))
    else $error("hasher not reset after digest");

  // a full block always starts its rounds
  assert property (@(posedge clk) disable iff (!rst_n)
    load_work |=> (state_r == ST_ROUND))
    else $error("full block not compressed");

endmodule
